[sv/cspn_pkg.sv]
// cspn_pkg: shared types and constants for the color sensor two point normalizer
// used by cspn_front, cspn_queue, cspn_back and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cspn_pkg;

  // field widths
  localparam int CMD_W = 2;
  localparam int COL_W = 2;
  localparam int ADC_W = 10;
  localparam int LVL_W = 8;
  localparam int ST_W  = 2;
  localparam int SUM_W = 14;
  localparam int CNT_W = 4;
  localparam int AVG_W = SUM_W;

  // samples summed per reading, legal range 1..15
  localparam int RUN_LEN = 10;

  // average by reciprocal: floor(sum / RUN_LEN) exact for any 14-bit sum
  localparam int AVG_SHIFT   = 20;
  localparam int AVG_RECIP   = (2 ** AVG_SHIFT + RUN_LEN - 1) / RUN_LEN;
  localparam int AVG_RECIP_W = AVG_SHIFT + 1;
  localparam int AVG_PROD_W  = SUM_W + AVG_RECIP_W;

  // calibration byte: floor(x / 1023) by reciprocal, x = avg * 255
  localparam int DVD_W       = AVG_W + 8;
  localparam int CAL_SHIFT   = 32;
  localparam longint unsigned CAL_RECIP = ((64'd1 << CAL_SHIFT) + 64'd1022) / 64'd1023;
  localparam int CAL_RECIP_W = 23;
  localparam int CAL_PROD_W  = DVD_W + CAL_RECIP_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SENSE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BLACK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WHITE = 2'd2;

  // highest legal color code
  localparam logic [COL_W-1:0] COL_BLUE = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_STORED = 2'd1;
  localparam logic [ST_W-1:0] ST_UNCAL  = 2'd2;
  localparam logic [ST_W-1:0] ST_DEGEN  = 2'd3;

  // input word
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [COL_W-1:0] color;
    logic [ADC_W-1:0] sample;
  } item_t;

  // result word
  typedef struct packed {
    logic [COL_W-1:0] out_color;
    logic [LVL_W-1:0] value;
    logic [ST_W-1:0]  status;
  } result_t;

  // closed reading handed from front to back
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [COL_W-1:0] color;
    logic [AVG_W-1:0] avg;
  } job_t;

endpackage

`default_nettype wire

[sv/cspn_queue.sv]
// cspn_queue: two-entry queue of closed readings between front and back
// depends on cspn_pkg (job_t)
`timescale 1ns / 1ps
`default_nettype none

module cspn_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  cspn_pkg::job_t     wr_job,
  output logic               full,
  input  wire logic          rd,
  output cspn_pkg::job_t     rd_job,
  output logic               empty
);

  cspn_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_wr;
  logic           do_rd;

  // status and handshakes
  always_comb begin
    full   = (count == 2'd2);
    empty  = (count == 2'd0);
    do_wr  = wr && !full;
    do_rd  = rd && !empty;
    rd_job = entries[rd_ptr];
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/cspn_front.sv]
// cspn_front: accepts sample words, sums runs and hands closed readings on
// depends on cspn_pkg (item_t, job_t, run constants)
`timescale 1ns / 1ps
`default_nettype none

module cspn_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  cspn_pkg::item_t    item,
  output logic               full,
  output logic               q_wr,
  output cspn_pkg::job_t     q_job,
  input  wire logic          q_full
);

  localparam logic [cspn_pkg::CNT_W-1:0] RunLenC = cspn_pkg::CNT_W'(cspn_pkg::RUN_LEN);
  localparam logic [cspn_pkg::AVG_RECIP_W-1:0] AvgRecipC =
    cspn_pkg::AVG_RECIP_W'(cspn_pkg::AVG_RECIP);

  // run registers
  logic [cspn_pkg::SUM_W-1:0] run_sum;
  logic [cspn_pkg::CNT_W-1:0] run_count;
  logic [cspn_pkg::CMD_W-1:0] run_command;
  logic [cspn_pkg::COL_W-1:0] run_color;

  // closing stage
  logic                       close_valid;
  logic [cspn_pkg::SUM_W-1:0] close_sum;
  logic [cspn_pkg::CMD_W-1:0] close_command;
  logic [cspn_pkg::COL_W-1:0] close_color;

  logic                            accept;
  logic                            legal;
  logic                            restart;
  logic [cspn_pkg::SUM_W-1:0]      sum_next;
  logic [cspn_pkg::CNT_W-1:0]      count_next;
  logic                            closes;
  logic [cspn_pkg::AVG_PROD_W-1:0] avg_prod;

  // accept and run bookkeeping
  always_comb begin
    full       = close_valid && q_full;
    accept     = push && !full;
    legal      = (item.command <= cspn_pkg::CMD_WHITE) && (item.color <= cspn_pkg::COL_BLUE);
    restart    = (run_count != '0) &&
                 ((item.command != run_command) || (item.color != run_color));
    sum_next   = (restart ? '0 : run_sum) + cspn_pkg::SUM_W'(item.sample);
    count_next = (restart ? '0 : run_count) + cspn_pkg::CNT_W'(1);
    closes     = (count_next >= RunLenC);
  end

  // average of a closed run and hand-off to the queue
  always_comb begin
    avg_prod    = cspn_pkg::AVG_PROD_W'(close_sum) * cspn_pkg::AVG_PROD_W'(AvgRecipC);
    q_wr        = close_valid;
    q_job.command = close_command;
    q_job.color   = close_color;
    q_job.avg     = avg_prod[cspn_pkg::AVG_SHIFT +: cspn_pkg::AVG_W];
  end

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum     <= '0;
      run_count   <= '0;
      run_command <= '0;
      run_color   <= '0;
    end else if (accept && legal) begin
      run_command <= item.command;
      run_color   <= item.color;
      if (closes) begin
        run_sum   <= '0;
        run_count <= '0;
      end else begin
        run_sum   <= sum_next;
        run_count <= count_next;
      end
    end
  end

  // closing stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      close_valid <= 1'b0;
    end else if (accept && legal && closes) begin
      close_valid <= 1'b1;
    end else if (close_valid && !q_full) begin
      close_valid <= 1'b0;
    end
  end

  // closing stage payload
  always_ff @(posedge clk) begin
    if (accept && legal && closes) begin
      close_sum     <= sum_next;
      close_command <= item.command;
      close_color   <= item.color;
    end
  end

endmodule

`default_nettype wire

[sv/cspn_back.sv]
// cspn_back: stores calibration levels and normalizes sense readings
// depends on cspn_pkg (job_t, result_t, codes); holds an 8-step divider
`timescale 1ns / 1ps
`default_nettype none

module cspn_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  cspn_pkg::job_t     q_job,
  input  wire logic          q_empty,
  output logic               q_rd,
  output cspn_pkg::result_t  result,
  output logic               empty,
  input  wire logic          pop
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_CAL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  localparam logic [cspn_pkg::CAL_RECIP_W-1:0] CalRecipC =
    cspn_pkg::CAL_RECIP_W'(cspn_pkg::CAL_RECIP);

  // b * 1023 / 255 == 4 * b + b / 85
  function automatic logic [cspn_pkg::ADC_W-1:0] expand(input logic [cspn_pkg::LVL_W-1:0] b);
    logic [1:0] extra;
    extra = (b == 8'd255) ? 2'd3 :
            ((b >= 8'd170) ? 2'd2 : ((b >= 8'd85) ? 2'd1 : 2'd0));
    return {b, 2'b00} + cspn_pkg::ADC_W'(extra);
  endfunction

  state_t state;

  // calibration store
  logic [cspn_pkg::LVL_W-1:0] black_level [3];
  logic [cspn_pkg::LVL_W-1:0] white_level [3];
  logic [1:0]                 level_known [3];

  // working registers
  cspn_pkg::job_t                  job;
  logic [cspn_pkg::CAL_PROD_W-1:0] cal_prod;
  logic [cspn_pkg::ADC_W-1:0]      diff;
  logic [cspn_pkg::ADC_W-1:0]      rem;
  logic [7:0]                      dvd_lo;
  logic [cspn_pkg::LVL_W-1:0]      quo;
  logic [2:0]                      step;
  logic [cspn_pkg::LVL_W-1:0]      val;
  logic [cspn_pkg::ST_W-1:0]       status;

  // result register
  cspn_pkg::result_t res;
  logic              res_valid;

  // sense preparation
  logic [1:0]                  col_idx;
  logic [cspn_pkg::ADC_W-1:0]  lo;
  logic [cspn_pkg::ADC_W-1:0]  hi;
  logic                        known;
  logic [cspn_pkg::AVG_W-1:0]  num;
  logic [cspn_pkg::DVD_W-1:0]  dvd;
  logic [cspn_pkg::DVD_W-1:0]  cal_x;
  logic                        above;
  logic                        sat;
  logic [cspn_pkg::AVG_W-1:0]  cal_q;
  logic [cspn_pkg::ADC_W:0]    rem2;
  logic                        fits;
  logic                        res_free;

  always_comb begin
    col_idx = (job.color > cspn_pkg::COL_BLUE) ? 2'd0 : job.color;
    lo      = expand(black_level[col_idx]);
    hi      = expand(white_level[col_idx]);
    known   = (level_known[col_idx] == 2'b11);
    above   = (job.avg > cspn_pkg::AVG_W'(lo));
    num     = job.avg - cspn_pkg::AVG_W'(lo);
    dvd     = (cspn_pkg::DVD_W'(num) << 8) - cspn_pkg::DVD_W'(num);
    sat     = (dvd[cspn_pkg::DVD_W-1:8] >= cspn_pkg::AVG_W'(hi - lo));
    cal_x   = (cspn_pkg::DVD_W'(job.avg) << 8) - cspn_pkg::DVD_W'(job.avg);
    cal_q   = cal_prod[cspn_pkg::CAL_SHIFT +: cspn_pkg::AVG_W];
  end

  // one restoring divide step
  always_comb begin
    rem2 = {rem, dvd_lo[7]};
    fits = (rem2 >= {1'b0, diff});
  end

  // handshakes
  always_comb begin
    q_rd     = (state == S_IDLE) && !q_empty;
    res_free = !res_valid || pop;
    empty    = !res_valid;
    result   = res;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (job.command != cspn_pkg::CMD_SENSE) begin
            state <= S_CAL;
          end else if (known && (hi > lo) && above && !sat) begin
            state <= S_DIV;
          end else begin
            state <= S_DONE;
          end
        end
        S_CAL: begin
          state <= S_DONE;
        end
        S_DIV: begin
          if (step == 3'd7) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_rd) begin
      job <= q_job;
    end
    if (state == S_PREP) begin
      cal_prod <= cspn_pkg::CAL_PROD_W'(cal_x) * cspn_pkg::CAL_PROD_W'(CalRecipC);
      diff     <= hi - lo;
      rem      <= dvd[8 +: cspn_pkg::ADC_W];
      dvd_lo   <= dvd[7:0];
      quo      <= '0;
      step     <= '0;
      if (job.command != cspn_pkg::CMD_SENSE) begin
        status <= cspn_pkg::ST_STORED;
      end else if (!known) begin
        status <= cspn_pkg::ST_UNCAL;
      end else if (hi <= lo) begin
        status <= cspn_pkg::ST_DEGEN;
      end else begin
        status <= cspn_pkg::ST_OK;
      end
      // quotient above the byte range saturates
      val <= ((job.command == cspn_pkg::CMD_SENSE) && known && (hi > lo) && above && sat) ?
             '1 : '0;
    end
    if (state == S_CAL) begin
      val <= (cal_q > cspn_pkg::AVG_W'(255)) ? '1 : cal_q[cspn_pkg::LVL_W-1:0];
    end
    if (state == S_DIV) begin
      rem    <= fits ? cspn_pkg::ADC_W'(rem2 - {1'b0, diff}) : rem2[cspn_pkg::ADC_W-1:0];
      dvd_lo <= {dvd_lo[6:0], 1'b0};
      quo    <= {quo[6:0], fits};
      step   <= step + 3'd1;
      if (step == 3'd7) begin
        val <= {quo[6:0], fits};
      end
    end
  end

  // calibration store updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        black_level[i] <= '0;
        white_level[i] <= '0;
        level_known[i] <= '0;
      end
    end else if (state == S_CAL) begin
      if (job.command == cspn_pkg::CMD_BLACK) begin
        black_level[col_idx] <=
          (cal_q > cspn_pkg::AVG_W'(255)) ? '1 : cal_q[cspn_pkg::LVL_W-1:0];
        level_known[col_idx] <= level_known[col_idx] | 2'b01;
      end else begin
        white_level[col_idx] <=
          (cal_q > cspn_pkg::AVG_W'(255)) ? '1 : cal_q[cspn_pkg::LVL_W-1:0];
        level_known[col_idx] <= level_known[col_idx] | 2'b10;
      end
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_DONE) && res_free) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && res_free) begin
      res.out_color <= job.color;
      res.value     <= val;
      res.status    <= status;
    end
  end

endmodule

`default_nettype wire

[sv/color_sensor_two_point_normalizer_unit.sv]
// color_sensor_two_point_normalizer_unit: top level of the two point normalizer
// depends on cspn_pkg, cspn_front, cspn_queue and cspn_back
//
//   port group   | handshake            | word
//   -------------+----------------------+--------------------------------------
//   input        | push / full          | item   : command, color, sample
//   result       | empty / pop          | result : out_color, value, status
//
// a sample word is taken whenever full is low; the tenth word of a run moves the
// reading into the front closing stage, where the average is formed, and it waits
// there until the two-entry queue has a slot. the back steps a calibration through
// prep, cal and done, a sense that needs no division through prep and done, and one
// that does through prep, the one bit per cycle divider and done.
// rst is synchronous and clears run state, calibration levels and queues.
// full rises only while a closed reading waits for a queue slot.
`timescale 1ns / 1ps
`default_nettype none

module color_sensor_two_point_normalizer_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  cspn_pkg::item_t    item,
  output logic               full,
  output cspn_pkg::result_t  result,
  output logic               empty,
  input  wire logic          pop
);

  logic           fq_wr;
  logic           fq_full;
  cspn_pkg::job_t fq_job;
  logic           bq_rd;
  logic           bq_empty;
  cspn_pkg::job_t bq_job;

  // run accumulation
  cspn_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_wr   (fq_wr),
    .q_job  (fq_job),
    .q_full (fq_full)
  );

  // closed readings between the two halves
  cspn_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (fq_wr),
    .wr_job (fq_job),
    .full   (fq_full),
    .rd     (bq_rd),
    .rd_job (bq_job),
    .empty  (bq_empty)
  );

  // calibration and normalization
  cspn_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_job   (bq_job),
    .q_empty (bq_empty),
    .q_rd    (bq_rd),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

`default_nettype wire

[sim/tb_color_sensor_two_point_normalizer_unit.sv]
// tb_color_sensor_two_point_normalizer_unit: self-checking bench for the two point normalizer
// depends on cspn_pkg and color_sensor_two_point_normalizer_unit; drives words, predicts readings
`timescale 1ns / 1ps

module tb_color_sensor_two_point_normalizer_unit;
  import cspn_pkg::*;

  // illegal codes, ignored by the block
  localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;
  localparam logic [COL_W-1:0] COL_BAD = 2'd3;
  localparam int ADC_MAX = 1023;
  localparam int BYTE_MAX = 255;
  localparam int SAMPLE_TARGET = 900;
  localparam int CALM_TAIL = 120;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int REPORT_CAP = 10;

  // running copy of the normalizer: run accumulation, levels, expected readings
  class reading_board;
    logic [SUM_W-1:0] run_acc = '0;
    logic [CNT_W-1:0] run_cnt = '0;
    logic [CMD_W-1:0] run_cmd = '0;
    logic [COL_W-1:0] run_col = '0;
    logic [LVL_W-1:0] black_byte [3] = '{default: '0};
    logic [LVL_W-1:0] white_byte [3] = '{default: '0};
    logic [1:0]       levels_set [3] = '{default: '0};
    result_t          pending [$];
    int failures = 0;
    int reported = 0;
    int readings_checked = 0;
    int status_seen [4] = '{default: 0};

    // accepted sample word: accumulate and queue a reading when a run closes
    function void note_sample(item_t w);
      int avg, lo, hi, val, k;
      result_t want;
      if (w.command > CMD_WHITE || w.color > COL_BLUE) return;
      if (run_cnt != 0 && (w.command != run_cmd || w.color != run_col)) begin
        run_acc = '0;
        run_cnt = '0;
      end
      run_cmd = w.command;
      run_col = w.color;
      run_acc = run_acc + SUM_W'(w.sample);
      run_cnt = run_cnt + CNT_W'(1);
      if (run_cnt < RUN_LEN) return;
      avg = int'(run_acc) / RUN_LEN;
      run_acc = '0;
      run_cnt = '0;
      k = int'(w.color);
      want.out_color = w.color;
      want.value = '0;
      want.status = ST_OK;
      if (w.command != CMD_SENSE) begin
        val = avg * BYTE_MAX / ADC_MAX;
        if (val > BYTE_MAX) val = BYTE_MAX;
        if (w.command == CMD_BLACK) begin
          black_byte[k] = LVL_W'(val);
          levels_set[k][0] = 1'b1;
        end else begin
          white_byte[k] = LVL_W'(val);
          levels_set[k][1] = 1'b1;
        end
        want.value = LVL_W'(val);
        want.status = ST_STORED;
      end else if (levels_set[k] != 2'b11) begin
        want.status = ST_UNCAL;
      end else begin
        lo = int'(black_byte[k]) * ADC_MAX / BYTE_MAX;
        hi = int'(white_byte[k]) * ADC_MAX / BYTE_MAX;
        if (hi <= lo) begin
          want.status = ST_DEGEN;
        end else if (avg > lo) begin
          val = (avg - lo) * BYTE_MAX / (hi - lo);
          if (val > BYTE_MAX) val = BYTE_MAX;
          want.value = LVL_W'(val);
        end
      end
      status_seen[want.status]++;
      pending.push_back(want);
    endfunction

    // popped reading: compare with the oldest expected one
    function void check_reading(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        failures++;
        if (reported < REPORT_CAP) begin
          reported++;
          $display("unexpected reading: color %0d value %0d status %0d",
                   got.out_color, got.value, got.status);
        end
        return;
      end
      want = pending.pop_front();
      readings_checked++;
      if (got.out_color !== want.out_color || got.value !== want.value ||
          got.status !== want.status) begin
        failures++;
        if (reported < REPORT_CAP) begin
          reported++;
          $display("reading %0d mismatch: expected color %0d value %0d status %0d, got %0d %0d %0d",
                   readings_checked, want.out_color, want.value, want.status,
                   got.out_color, got.value, got.status);
        end
      end
    endfunction

    // readings still owed at the end
    function void flag_missing();
      if (pending.size() != 0) begin
        failures += pending.size();
        $display("%0d expected readings never arrived", pending.size());
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  item_t   item = '0;
  logic    full;
  result_t result;
  logic    empty;
  logic    pop = 1'b0;

  reading_board board = new();
  int  quiet_cycles = 0;
  int  legal_sent = 0;
  int  noise_sent = 0;
  bit  calm = 1'b0;
  bit  sender_gaps = 1'b0;
  bit  reader_gaps = 1'b1;
  int  hold_left = 0;

  color_sensor_two_point_normalizer_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

  // 8 ns clock
  always #4 clk = ~clk;

  // observe handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) board.note_sample(item);
      if (pop && !empty) board.check_reading(result);
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // result side: pop with random stall bursts, none started in the calm tail
  always @(negedge clk) begin
    if (rst) begin
      pop = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop = 1'b0;
    end else if (!calm && reader_gaps && $urandom_range(0, 3) == 0) begin
      hold_left = $urandom_range(0, 8);
      pop = 1'b0;
    end else begin
      pop = 1'b1;
    end
    if ($urandom_range(0, 63) == 0) reader_gaps = !reader_gaps;
  end

  // watchdog on cycles with no word moving
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
    $display("color_sensor_two_point_normalizer_unit regression: fail");
    $finish;
  end

  // one sample word, with an optional idle burst ahead of it
  task automatic send_word(input logic [CMD_W-1:0] c, input logic [COL_W-1:0] k,
                           input logic [ADC_W-1:0] s);
    int gap;
    if (!calm && sender_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.command = c;
    item.color = k;
    item.sample = s;
    push = 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
    if (c <= CMD_WHITE && k <= COL_BLUE) legal_sent++;
    else noise_sent++;
  endtask

  // word with an illegal command or color
  task automatic send_noise();
    logic [CMD_W-1:0] c;
    logic [COL_W-1:0] k;
    c = CMD_W'($urandom_range(0, 3));
    k = (c == CMD_BAD) ? COL_W'($urandom_range(0, 3)) : COL_BAD;
    send_word(c, k, ADC_W'($urandom_range(0, ADC_MAX)));
  endtask

  // hold off until every expected reading has been popped
  task automatic drain_readings();
    push = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  // stimulus
  initial begin
    logic [CMD_W-1:0] c;
    logic [COL_W-1:0] k;
    int len, base, spread, v;
    bit wild, paused;

    paused = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: ignored codes, uncalibrated sense at extremes, broken run, full white
    send_word(CMD_BAD, 2'd1, ADC_W'(ADC_MAX));
    send_word(CMD_SENSE, COL_BAD, '0);
    for (int i = 0; i < RUN_LEN; i++)
      send_word(CMD_SENSE, 2'd0, (i % 2) ? ADC_W'(ADC_MAX) : '0);
    for (int i = 0; i < 3; i++) send_word(CMD_BLACK, 2'd1, ADC_W'(ADC_MAX));
    for (int i = 0; i < RUN_LEN; i++) send_word(CMD_WHITE, 2'd1, ADC_W'(ADC_MAX));
    drain_readings();

    // random runs: mostly whole runs, some cut short, some noise
    while (legal_sent < SAMPLE_TARGET) begin
      calm = (legal_sent >= SAMPLE_TARGET - CALM_TAIL);
      if (!paused && legal_sent >= SAMPLE_TARGET / 2) begin
        drain_readings();
        paused = 1'b1;
      end
      sender_gaps = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 19))
        0: begin
          send_noise();
        end
        default: begin
          case ($urandom_range(0, 3))
            0, 1: c = CMD_SENSE;
            2: c = CMD_BLACK;
            default: c = CMD_WHITE;
          endcase
          k = COL_W'($urandom_range(0, 2));
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, RUN_LEN - 1) : RUN_LEN;
          // black levels lean low, white high, so most ranges are usable
          if ($urandom_range(0, 4) == 0 || c == CMD_SENSE) base = $urandom_range(0, ADC_MAX);
          else if (c == CMD_BLACK) base = $urandom_range(0, 700);
          else base = $urandom_range(300, ADC_MAX);
          wild = ($urandom_range(0, 5) == 0);
          spread = $urandom_range(0, 30);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 29) == 0) send_noise();
            if (wild) begin
              v = $urandom_range(0, ADC_MAX);
            end else begin
              v = base + $urandom_range(0, 2 * spread) - spread;
              if (v < 0) v = 0;
              if (v > ADC_MAX) v = ADC_MAX;
            end
            send_word(c, k, ADC_W'(v));
          end
        end
      endcase
    end

    // wind down
    push = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    board.flag_missing();

    $display("run: %0d samples and %0d ignored words, %0d readings checked",
             legal_sent, noise_sent, board.readings_checked);
    $display("readings: %0d sensed, %0d stored, %0d uncalibrated, %0d degenerate range",
             board.status_seen[ST_OK], board.status_seen[ST_STORED],
             board.status_seen[ST_UNCAL], board.status_seen[ST_DEGEN]);
    if (board.failures == 0) begin
      $display("color_sensor_two_point_normalizer_unit regression: pass");
    end else begin
      $display("color_sensor_two_point_normalizer_unit regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/cspn_pkg.sv
sv/cspn_queue.sv
sv/cspn_front.sv
sv/cspn_back.sv
sv/color_sensor_two_point_normalizer_unit.sv
sim/tb_color_sensor_two_point_normalizer_unit.sv
